FILE: rtl/button_digit_counter_fsm_defines.svh
// Assertion macros shared by the counter RTL.
`ifndef BUTTON_DIGIT_COUNTER_FSM_DEFINES_SVH
`define BUTTON_DIGIT_COUNTER_FSM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDC_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("counter assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BDC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("counter assertion failed");

`endif

FILE: rtl/bdc_pkg.sv
// Shared types and constants of the button digit counter.
package bdc_pkg;

  localparam int DIGIT_W = 4;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE       = 2'd2;

  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 8'd3;
  localparam logic [CFG_W-1:0] REPEAT_RST     = 8'd1;
  localparam logic [CFG_W-1:0] IDLE_RST       = 8'd10;

  localparam logic [DIGIT_W-1:0] DIGIT_RST = 4'd1;

  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_AUTO_INC  = 2'd1,
    MODE_AUTO_DEC  = 2'd2,
    MODE_COUNTDOWN = 2'd3
  } mode_t;

  // Sticky per-button event flags; the same shape carries clear requests.
  typedef struct packed {
    logic pressed;
    logic released;
    logic long_press;
  } btn_flags_t;

endpackage

FILE: rtl/bdc_button.sv
// Per-button press / release / long-press tracker with its hold timer.
module bdc_button #(
  parameter int TIMER_WIDTH = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   level,
  input  logic                   tick,
  input  logic [TIMER_WIDTH-1:0] load_val,
  input  bdc_pkg::btn_flags_t    clr,
  output bdc_pkg::btn_flags_t    flags
);

  logic                   held_r, held_nxt;
  bdc_pkg::btn_flags_t    flags_r, flags_nxt;
  logic [TIMER_WIDTH-1:0] timer_r, timer_nxt, timer_t;
  logic                   exp_r, exp_nxt, exp_t;

  // timer counts down first
  always_comb begin
    timer_t = timer_r;
    exp_t   = exp_r;
    if (tick && (timer_r != '0)) begin
      timer_t = timer_r - TIMER_WIDTH'(1);
      if (timer_r == TIMER_WIDTH'(1)) begin
        exp_t = 1'b1;
      end
    end
  end

  always_comb begin
    held_nxt  = held_r;
    flags     = flags_r;
    timer_nxt = timer_t;
    exp_nxt   = exp_t;
    if (!held_r) begin
      if (level) begin
        held_nxt      = 1'b1;
        flags.pressed = 1'b1;
        timer_nxt     = load_val;
        exp_nxt       = 1'b0;
      end
    end else if (!level) begin
      flags.released = 1'b1;
      held_nxt       = 1'b0;
    end else if (exp_t) begin
      flags.long_press = 1'b1;
      exp_nxt          = 1'b0;
    end
    flags_nxt.pressed    = flags.pressed & ~clr.pressed;
    flags_nxt.released   = flags.released & ~clr.released;
    flags_nxt.long_press = flags.long_press & ~clr.long_press;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 1'b0;
      flags_r <= '0;
      timer_r <= '0;
      exp_r   <= 1'b0;
    end else if (en) begin
      held_r  <= held_nxt;
      flags_r <= flags_nxt;
      timer_r <= timer_nxt;
      exp_r   <= exp_nxt;
    end
  end

endmodule

FILE: rtl/bdc_mode_ctrl.sv
// Mode state machine, digit register and mode timer.
module bdc_mode_ctrl #(
  parameter int TIMER_WIDTH = 8,
  parameter int DIGIT_MAX   = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          tick,
  input  logic [TIMER_WIDTH-1:0]        repeat_val,
  input  logic [TIMER_WIDTH-1:0]        idle_val,
  input  bdc_pkg::btn_flags_t           rst_flags,
  input  bdc_pkg::btn_flags_t           inc_flags,
  input  bdc_pkg::btn_flags_t           dec_flags,
  output bdc_pkg::btn_flags_t           rst_clr,
  output bdc_pkg::btn_flags_t           inc_clr,
  output bdc_pkg::btn_flags_t           dec_clr,
  output logic [bdc_pkg::DIGIT_W-1:0]   digit_nxt,
  output bdc_pkg::mode_t                mode_nxt,
  output logic                          step
);

  localparam logic [bdc_pkg::DIGIT_W-1:0] DMAX = bdc_pkg::DIGIT_W'(DIGIT_MAX);

  bdc_pkg::mode_t                mode_r;
  logic [bdc_pkg::DIGIT_W-1:0]   digit_r, digit_up, digit_dn;
  logic [TIMER_WIDTH-1:0]        timer_r, timer_nxt, timer_t;
  logic                          exp_r, exp_nxt, exp_t;
  logic                          load_rep, load_idle;
  logic                          short_press;

  always_comb begin
    timer_t = timer_r;
    exp_t   = exp_r;
    if (tick && (timer_r != '0)) begin
      timer_t = timer_r - TIMER_WIDTH'(1);
      if (timer_r == TIMER_WIDTH'(1)) begin
        exp_t = 1'b1;
      end
    end
  end

  assign digit_up    = (digit_r >= DMAX) ? '0 : digit_r + bdc_pkg::DIGIT_W'(1);
  assign digit_dn    = (digit_r == '0) ? DMAX : digit_r - bdc_pkg::DIGIT_W'(1);
  assign short_press = rst_flags.pressed | inc_flags.pressed | dec_flags.pressed;

  // next state
  always_comb begin
    mode_nxt = mode_r;
    case (mode_r)
      bdc_pkg::MODE_NORMAL: begin
        if (inc_flags.long_press) begin
          mode_nxt = bdc_pkg::MODE_AUTO_INC;
        end else if (dec_flags.long_press) begin
          mode_nxt = bdc_pkg::MODE_AUTO_DEC;
        end else if (short_press) begin
          mode_nxt = bdc_pkg::MODE_NORMAL;
        end else if (exp_t) begin
          mode_nxt = bdc_pkg::MODE_COUNTDOWN;
        end
      end
      bdc_pkg::MODE_AUTO_INC: begin
        if (inc_flags.released) begin
          mode_nxt = bdc_pkg::MODE_NORMAL;
        end
      end
      bdc_pkg::MODE_AUTO_DEC: begin
        if (dec_flags.released) begin
          mode_nxt = bdc_pkg::MODE_NORMAL;
        end
      end
      default: begin
        if (short_press) begin
          mode_nxt = bdc_pkg::MODE_NORMAL;
        end
      end
    endcase
  end

  // outputs: digit, timer loads, flag clears, countdown step
  always_comb begin
    digit_nxt = digit_r;
    load_rep  = 1'b0;
    load_idle = 1'b0;
    rst_clr   = '0;
    inc_clr   = '0;
    dec_clr   = '0;
    step      = 1'b0;
    case (mode_r)
      bdc_pkg::MODE_NORMAL, bdc_pkg::MODE_COUNTDOWN: begin
        if ((mode_r == bdc_pkg::MODE_NORMAL) && inc_flags.long_press) begin
          inc_clr.long_press = 1'b1;
          digit_nxt          = digit_up;
          load_rep           = 1'b1;
        end else if ((mode_r == bdc_pkg::MODE_NORMAL) && dec_flags.long_press) begin
          dec_clr.long_press = 1'b1;
          digit_nxt          = digit_dn;
          load_rep           = 1'b1;
        end else if (rst_flags.pressed) begin
          rst_clr.pressed = 1'b1;
          digit_nxt       = '0;
          load_idle       = 1'b1;
        end else if (inc_flags.pressed) begin
          inc_clr.pressed = 1'b1;
          digit_nxt       = digit_up;
          load_idle       = 1'b1;
        end else if (dec_flags.pressed) begin
          dec_clr.pressed = 1'b1;
          digit_nxt       = digit_dn;
          load_idle       = 1'b1;
        end else if (exp_t) begin
          load_rep = 1'b1;
          if (mode_r == bdc_pkg::MODE_COUNTDOWN) begin
            step = 1'b1;
            if (digit_r != '0) begin
              digit_nxt = digit_r - bdc_pkg::DIGIT_W'(1);
            end
          end
        end
      end
      bdc_pkg::MODE_AUTO_INC: begin
        if (inc_flags.released) begin
          inc_clr.released = 1'b1;
          load_idle        = 1'b1;
        end else if (exp_t) begin
          load_rep  = 1'b1;
          digit_nxt = digit_up;
        end
      end
      default: begin
        if (dec_flags.released) begin
          dec_clr.released = 1'b1;
          load_idle        = 1'b1;
        end else if (exp_t) begin
          load_rep  = 1'b1;
          digit_nxt = digit_dn;
        end
      end
    endcase
  end

  always_comb begin
    timer_nxt = timer_t;
    exp_nxt   = exp_t;
    if (load_rep) begin
      timer_nxt = repeat_val;
      exp_nxt   = 1'b0;
    end else if (load_idle) begin
      timer_nxt = idle_val;
      exp_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= bdc_pkg::MODE_COUNTDOWN;
      digit_r <= bdc_pkg::DIGIT_RST;
      timer_r <= '0;
      exp_r   <= 1'b0;
    end else if (en) begin
      mode_r  <= mode_nxt;
      digit_r <= digit_nxt;
      timer_r <= timer_nxt;
      exp_r   <= exp_nxt;
    end
  end

endmodule

FILE: rtl/button_digit_counter_fsm.sv
// Top level of the up/down digit counter with long-press repeat and idle countdown.
//
// Usage:
//  - Input channel (in_valid/in_ready): one transaction per loop step, carrying the
//    debounced reset/inc/dec button levels and the one-second tick.
//  - Output channel (out_valid/out_ready): one transaction per input transaction,
//    with the digit, the mode and the countdown-step strobe after that step.
//  - Config port (cfg_we/cfg_index/cfg_data): index 0 long-press seconds, 1 repeat
//    seconds, 2 idle seconds; other indexes are ignored. Write only when idle.
//  - Path: the accepting edge loads the input register; the step then runs and loads
//    the result register once that register is free or being read out.
//  - Throughput: one transaction per cycle while out_ready is high; the per-step
//    logic between the two registers is a single pass of compares and counters.
//  - Stall: when out_ready is low the result holds, the input register holds its
//    transaction and in_ready drops once that register is full.
//  - Reset (rst_n low, synchronous): mode countdown, digit 1, all buttons released,
//    all flags and timers clear, config back to 3 / 1 / 10 seconds.
`include "button_digit_counter_fsm_defines.svh"

module button_digit_counter_fsm #(
  parameter int TIMER_WIDTH = 8,
  parameter int DIGIT_MAX   = 9
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_reset_button,
  input  logic                            in_inc_button,
  input  logic                            in_dec_button,
  input  logic                            in_second_tick,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bdc_pkg::DIGIT_W-1:0]     out_digit,
  output logic [1:0]                      out_mode,
  output logic                            out_countdown_step,
  input  logic                            cfg_we,
  input  logic [bdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdc_pkg::CFG_W-1:0]       cfg_data
);

  // Wide enough to compare an 8-bit config value against the timer limit.
  localparam int LW = (TIMER_WIDTH > bdc_pkg::CFG_W) ? TIMER_WIDTH : bdc_pkg::CFG_W;
  localparam logic [LW-1:0] TMR_LIM = LW'({TIMER_WIDTH{1'b1}});

  // Saturating load: values beyond the timer range pin at all ones.
  function automatic logic [TIMER_WIDTH-1:0] clamp_load(input logic [bdc_pkg::CFG_W-1:0] v);
    logic [LW-1:0] ext;
    ext = LW'(v);
    clamp_load = (ext > TMR_LIM) ? TIMER_WIDTH'(TMR_LIM) : TIMER_WIDTH'(ext);
  endfunction

  // Config registers hold the already clamped load values.
  logic [TIMER_WIDTH-1:0] long_press_r, repeat_r, idle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= clamp_load(bdc_pkg::LONG_PRESS_RST);
      repeat_r     <= clamp_load(bdc_pkg::REPEAT_RST);
      idle_r       <= clamp_load(bdc_pkg::IDLE_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        bdc_pkg::CFG_LONG_PRESS: long_press_r <= clamp_load(cfg_data);
        bdc_pkg::CFG_REPEAT:     repeat_r     <= clamp_load(cfg_data);
        bdc_pkg::CFG_IDLE:       idle_r       <= clamp_load(cfg_data);
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic       s1_valid_r;
  logic [2:0] s1_level_r;
  logic       s1_tick_r;
  logic       s1_fire;

  // The step runs when stage 1 holds a transaction and the result register frees.
  assign s1_fire  = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_level_r <= {in_dec_button, in_inc_button, in_reset_button};
      s1_tick_r  <= in_second_tick;
    end
  end

  // Step logic: button trackers feed the mode machine, which clears consumed flags.
  bdc_pkg::btn_flags_t rst_flags, inc_flags, dec_flags;
  bdc_pkg::btn_flags_t rst_clr, inc_clr, dec_clr;
  logic [bdc_pkg::DIGIT_W-1:0] digit_nxt;
  bdc_pkg::mode_t              mode_nxt;
  logic                        step;

  bdc_button #(.TIMER_WIDTH(TIMER_WIDTH)) u_btn_rst (
    .clk(clk), .rst_n(rst_n), .en(s1_fire), .level(s1_level_r[0]), .tick(s1_tick_r),
    .load_val(long_press_r), .clr(rst_clr), .flags(rst_flags)
  );

  bdc_button #(.TIMER_WIDTH(TIMER_WIDTH)) u_btn_inc (
    .clk(clk), .rst_n(rst_n), .en(s1_fire), .level(s1_level_r[1]), .tick(s1_tick_r),
    .load_val(long_press_r), .clr(inc_clr), .flags(inc_flags)
  );

  bdc_button #(.TIMER_WIDTH(TIMER_WIDTH)) u_btn_dec (
    .clk(clk), .rst_n(rst_n), .en(s1_fire), .level(s1_level_r[2]), .tick(s1_tick_r),
    .load_val(long_press_r), .clr(dec_clr), .flags(dec_flags)
  );

  bdc_mode_ctrl #(.TIMER_WIDTH(TIMER_WIDTH), .DIGIT_MAX(DIGIT_MAX)) u_mode (
    .clk(clk), .rst_n(rst_n), .en(s1_fire), .tick(s1_tick_r),
    .repeat_val(repeat_r), .idle_val(idle_r),
    .rst_flags(rst_flags), .inc_flags(inc_flags), .dec_flags(dec_flags),
    .rst_clr(rst_clr), .inc_clr(inc_clr), .dec_clr(dec_clr),
    .digit_nxt(digit_nxt), .mode_nxt(mode_nxt), .step(step)
  );

  // Result register.
  logic                        out_valid_r;
  logic [bdc_pkg::DIGIT_W-1:0] out_digit_r;
  bdc_pkg::mode_t              out_mode_r;
  logic                        out_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_digit_r <= digit_nxt;
      out_mode_r  <= mode_nxt;
      out_step_r  <= step;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_digit          = out_digit_r;
  assign out_mode           = out_mode_r;
  assign out_countdown_step = out_step_r;

  // A step always lands in the result register.
  `BDC_ASSERT_NEXT(a_fire_loads_out, clk, rst_n, s1_fire, out_valid_r)
  // The digit never leaves its range.
  `BDC_ASSERT_NOW(a_digit_range, clk, rst_n, out_valid_r,
                  out_digit_r <= bdc_pkg::DIGIT_W'(DIGIT_MAX))
  // Countdown strobe only comes with the countdown mode.
  `BDC_ASSERT_NOW(a_step_mode, clk, rst_n, out_valid_r && out_step_r,
                  out_mode_r == bdc_pkg::MODE_COUNTDOWN)
  // An empty input register always takes a transaction.
  `BDC_ASSERT_NOW(a_empty_ready, clk, rst_n, !s1_valid_r, in_ready)

endmodule
